### rtl/rsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request slot allocator package
// Shared widths, operation codes and result status codes for the allocator.
// ----------------------------------------------------------------------------
package rsa_pkg;

    // Pool geometry. The slot field is four bits wide, which fixes the pool.
    localparam int SLOTS  = 16;
    localparam int SLOT_W = 4;
    localparam int COUNT_W = 5;
    localparam int ID_W   = 32;

    // Reset value of the active slot register.
    localparam logic [COUNT_W-1:0] ACTIVE_RESET = 5'd16;

    // Operation requested by an input transfer.
    typedef enum logic [1:0] {
        OP_LOOKUP   = 2'd0,
        OP_ALLOCATE = 2'd1,
        OP_RELEASE  = 2'd2,
        OP_REINIT   = 2'd3
    } op_t;

    // Status returned with every result transfer.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_HELD      = 2'd1,
        ST_EXHAUSTED = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

endpackage

### rtl/request_slot_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request slot allocator
// Maps 32-bit request identifiers onto a pool of sequence slots using an
// owner table with parallel compare and a LIFO free stack.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake             Payload
//  input     in         in_valid / in_stall   op, request_id
//  result    out        out_valid / out_stall status, slot, free_count
//  config    in         cfg_valid / cfg_ready cfg_data (active_slots)
//
// One input transfer is accepted per cycle while in_stall is low. A request
// is captured in an input register, resolved in one pass of owner compare
// and stack update, and its result moves to the output register when free.
// The owner compare and stack access between the two registers set the rate.
// Reset empties the owner table and fills the stack with slots 0 to 15; no
// clearing pass is needed. A stalled result holds both stages in place.
// ----------------------------------------------------------------------------
module request_slot_allocator (
    input  logic                          clk,
    input  logic                          rst_n,
    // Input channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    op,
    input  logic [rsa_pkg::ID_W-1:0]      request_id,
    // Result channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    status,
    output logic [rsa_pkg::SLOT_W-1:0]    slot,
    output logic [rsa_pkg::COUNT_W-1:0]   free_count,
    // Configuration channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rsa_pkg::COUNT_W-1:0]   cfg_data
);

    localparam int SLOTS   = rsa_pkg::SLOTS;
    localparam int SLOT_W  = rsa_pkg::SLOT_W;
    localparam int COUNT_W = rsa_pkg::COUNT_W;
    localparam int ID_W    = rsa_pkg::ID_W;
    localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(SLOTS);

    // Configuration and pool state.
    logic [COUNT_W-1:0]   active_slots_reg;
    logic [SLOTS-1:0]     slot_valid_reg;
    logic [ID_W-1:0]      slot_owner_reg [SLOTS];
    logic [SLOT_W-1:0]    free_stack_reg [SLOTS];
    logic [COUNT_W-1:0]   free_top_reg;
    logic [COUNT_W-1:0]   free_top_next;

    // Input stage.
    logic                 s1_valid_reg;
    rsa_pkg::op_t         op_reg;
    logic [ID_W-1:0]      id_reg;

    // Output stage.
    logic                 out_valid_reg;
    rsa_pkg::status_t     status_reg;
    rsa_pkg::status_t     status_next;
    logic [SLOT_W-1:0]    slot_reg;
    logic [SLOT_W-1:0]    slot_next;
    logic [COUNT_W-1:0]   free_count_reg;

    // Pipeline control.
    logic                 out_ready;
    logic                 fire;
    logic                 in_accept;

    // Per-request decisions.
    logic                 hit_found;
    logic [SLOT_W-1:0]    hit_idx;
    logic [SLOT_W-1:0]    pop_idx;
    logic [SLOT_W-1:0]    push_idx;
    logic                 do_alloc;
    logic                 do_release;
    logic                 do_push;
    logic                 do_reinit;
    logic [COUNT_W-1:0]   active_clamped;

    // The output register frees up when empty or when its result is taken.
    assign out_ready = !out_valid_reg || !out_stall;
    assign fire      = s1_valid_reg && out_ready;
    assign in_stall  = s1_valid_reg && !out_ready;
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign slot       = slot_reg;
    assign free_count = free_count_reg;

    // Configuration register write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_slots_reg <= rsa_pkg::ACTIVE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            active_slots_reg <= cfg_data;
        end
    end

    // Input register capture.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg <= rsa_pkg::op_t'(op);
            id_reg <= request_id;
        end
    end

    // Owner search: lowest valid slot whose owner matches the request.
    always_comb
    begin
        hit_found = 1'b0;
        hit_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (slot_valid_reg[i] && (slot_owner_reg[i] == id_reg))
            begin
                hit_found = 1'b1;
                hit_idx   = SLOT_W'(i);
            end
        end
    end

    // Stack addresses and the clamped pool size.
    assign pop_idx        = SLOT_W'(free_top_reg - COUNT_W'(1));
    assign push_idx       = free_top_reg[SLOT_W-1:0];
    assign active_clamped = (active_slots_reg > FULL_COUNT) ? FULL_COUNT : active_slots_reg;

    // Decide the operation outcome and the next stack top.
    always_comb
    begin
        status_next   = rsa_pkg::ST_OK;
        slot_next     = '0;
        free_top_next = free_top_reg;
        do_alloc      = 1'b0;
        do_release    = 1'b0;
        do_push       = 1'b0;
        do_reinit     = 1'b0;
        unique case (op_reg)
            rsa_pkg::OP_LOOKUP:
            begin
                if (hit_found)
                begin
                    slot_next = hit_idx;
                end
                else
                begin
                    status_next = rsa_pkg::ST_NOT_FOUND;
                end
            end
            rsa_pkg::OP_ALLOCATE:
            begin
                if (hit_found)
                begin
                    status_next = rsa_pkg::ST_HELD;
                    slot_next   = hit_idx;
                end
                else if (free_top_reg == '0)
                begin
                    status_next = rsa_pkg::ST_EXHAUSTED;
                end
                else
                begin
                    do_alloc      = fire;
                    slot_next     = free_stack_reg[pop_idx];
                    free_top_next = free_top_reg - COUNT_W'(1);
                end
            end
            rsa_pkg::OP_RELEASE:
            begin
                if (hit_found)
                begin
                    do_release = fire;
                    slot_next  = hit_idx;
                    if (free_top_reg < FULL_COUNT)
                    begin
                        do_push       = fire;
                        free_top_next = free_top_reg + COUNT_W'(1);
                    end
                end
                else
                begin
                    status_next = rsa_pkg::ST_NOT_FOUND;
                end
            end
            rsa_pkg::OP_REINIT:
            begin
                do_reinit     = fire;
                free_top_next = active_clamped;
            end
            default:
            begin
                status_next = rsa_pkg::ST_OK;
            end
        endcase
    end

    // Valid marks, free stack and stack top.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= '0;
            free_top_reg   <= (rsa_pkg::ACTIVE_RESET > FULL_COUNT) ? FULL_COUNT
                                                                   : rsa_pkg::ACTIVE_RESET;
            for (int i = 0; i < SLOTS; i++)
            begin
                free_stack_reg[i] <= SLOT_W'(i);
            end
        end
        else if (fire)
        begin
            free_top_reg <= free_top_next;
            if (do_reinit)
            begin
                slot_valid_reg <= '0;
                for (int i = 0; i < SLOTS; i++)
                begin
                    free_stack_reg[i] <= SLOT_W'(i);
                end
            end
            if (do_alloc)
            begin
                slot_valid_reg[slot_next] <= 1'b1;
            end
            if (do_release)
            begin
                slot_valid_reg[hit_idx] <= 1'b0;
            end
            if (do_push)
            begin
                free_stack_reg[push_idx] <= hit_idx;
            end
        end
    end

    // Owner table, written on a successful allocate.
    always_ff @(posedge clk)
    begin
        if (do_alloc)
        begin
            slot_owner_reg[slot_next] <= id_reg;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            status_reg     <= status_next;
            slot_reg       <= slot_next;
            free_count_reg <= free_top_next;
        end
    end

endmodule
